// File: rtl/calendar_date_add_days_defines.svh
// Assertion macros for the date stepper.
// Included by the top level; relies on clock and reset being in scope.
`ifndef CALENDAR_DATE_ADD_DAYS_DEFINES_SVH
`define CALENDAR_DATE_ADD_DAYS_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CDAD_ASSERT_SAME(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("cdad check failed");

// Next-cycle implication, disabled during reset
`define CDAD_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("cdad check failed");

`endif

// File: rtl/cdad_pkg.sv
// Shared constants, widths and status codes for the date stepper.
// No dependencies; used by the interfaces and all modules.
package cdad_pkg;

   // field widths
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int OFFSET_W = 17;
   localparam int DOY_W    = 9;
   localparam int WORK_W   = 19;   // signed day count, -262144 to 262143
   localparam int MLEN_W   = 5;

   // range limits
   localparam int YEAR_MAX   = 9999;
   localparam int OFFSET_MAX = 65535;

   // calendar constants
   localparam int MONTHS      = 12;
   localparam int LEAP_CYCLE  = 400;
   localparam int CENTURY     = 100;
   localparam int COMMON_DAYS = 365;
   localparam int RES_W       = 9;     // holds a residue below LEAP_CYCLE
   localparam int MOD_TOP     = 5;     // LEAP_CYCLE << MOD_TOP is the largest fitting step
   localparam int STEP_W      = 3;

   localparam logic [MONTH_W-1:0] FEBRUARY  = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] APRIL     = MONTH_W'(4);
   localparam logic [MONTH_W-1:0] JUNE      = MONTH_W'(6);
   localparam logic [MONTH_W-1:0] SEPTEMBER = MONTH_W'(9);
   localparam logic [MONTH_W-1:0] NOVEMBER  = MONTH_W'(11);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_DATE = 2'd1,
      STATUS_RANGE    = 2'd2
   } status_type;

endpackage

// File: rtl/cdad_req_if.sv
// Request channel: start date and signed day offset, valid/ready.
// Depends on cdad_pkg.
interface cdad_req_if;
   import cdad_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [DAY_W-1:0]           start_day;
   logic [MONTH_W-1:0]         start_month;
   logic [YEAR_W-1:0]          start_year;
   logic signed [OFFSET_W-1:0] day_offset;

   modport source (output valid, start_day, start_month, start_year, day_offset,
                   input ready);
   modport sink   (input valid, start_day, start_month, start_year, day_offset,
                   output ready);
endinterface

// Response channel: resulting date, ordinal day and status, valid/ready.
// Depends on cdad_pkg.
interface cdad_rsp_if;
   import cdad_pkg::*;

   logic               valid;
   logic               ready;
   logic [DAY_W-1:0]   res_day;
   logic [MONTH_W-1:0] res_month;
   logic [YEAR_W-1:0]  res_year;
   logic [DOY_W-1:0]   day_of_year;
   status_type         status;

   modport source (output valid, res_day, res_month, res_year, day_of_year, status,
                   input ready);
   modport sink   (input valid, res_day, res_month, res_year, day_of_year, status,
                   output ready);
endinterface

// File: rtl/cdad_mlen.sv
// Month length lookup under the Gregorian rule.
// Depends on cdad_pkg.
module cdad_mlen (
   input  logic [cdad_pkg::MONTH_W-1:0] month,
   input  logic                         leap,
   output logic [cdad_pkg::MLEN_W-1:0]  len
);
   import cdad_pkg::*;

   // February depends on leap; the four short months have 30 days
   always_comb begin
      case (month) inside
         FEBRUARY:                         len = leap ? MLEN_W'(29) : MLEN_W'(28);
         APRIL, JUNE, SEPTEMBER, NOVEMBER: len = MLEN_W'(30);
         default:                          len = MLEN_W'(31);
      endcase
   end
endmodule

// File: rtl/cdad_alu.sv
// Shared signed add/subtract unit with sign flag.
// Depends on cdad_pkg.
module cdad_alu (
   input  logic signed [cdad_pkg::WORK_W-1:0] op_a,
   input  logic signed [cdad_pkg::WORK_W-1:0] op_b,
   input  logic                               sub,
   output logic signed [cdad_pkg::WORK_W-1:0] sum,
   output logic                               neg
);
   import cdad_pkg::*;

   // a + b or a - b, neg marks a negative result
   always_comb begin
      sum = sub ? (op_a - op_b) : (op_a + op_b);
      neg = sum[WORK_W-1];
   end
endmodule

// File: rtl/calendar_date_add_days.sv
// Gregorian date stepper: moves a start date by a signed number of days.
// Channels: req (start_day, start_month, start_year, day_offset) and rsp
// (res_day, res_month, res_year, day_of_year, status), both valid/ready;
// a beat moves when valid and ready are high at a rising clock edge.
// One request at a time: req.ready is high only while the sequencer is idle.
// A request passes through these steps in order: the year is reduced modulo 400,
// the date is checked, the earlier months are summed, the offset is added, then
// one year per cycle is stepped through the shared adder (up to 180 years for
// the largest offset), then month by month, and the result is loaded into the
// output register; the year loop through the single add/subtract unit is the
// longest step. A new request is taken the cycle after a response is loaded;
// the block takes no new request until it is through with the last one. An
// invalid start date answers straight after the check with status 1.
// The response sits in an output register; if the receiver stalls, the
// finished result waits there and the next result waits in its last state.
// Reset (synchronous, active high) returns to idle and drops rsp.valid.
// Depends on cdad_pkg, cdad_req_if, cdad_rsp_if, cdad_alu and cdad_mlen.
`include "calendar_date_add_days_defines.svh"

module calendar_date_add_days (
   input  logic      clock,
   input  logic      reset,
   cdad_req_if.sink  req_ch,
   cdad_rsp_if.source rsp_ch
);
   import cdad_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_MOD, S_CHECK, S_ORD, S_OFFS, S_YEAR, S_MONTH, S_DONE
   } state_type;

   localparam logic signed [OFFSET_W:0] OFF_LIM = (OFFSET_W + 1)'(OFFSET_MAX);
   localparam logic [YEAR_W-1:0] YEAR_LAST = YEAR_W'(YEAR_MAX);
   localparam logic [RES_W-1:0]  RES_LAST  = RES_W'(LEAP_CYCLE - 1);

   state_type                   state_ff;
   logic [DAY_W-1:0]            sd_ff;
   logic [MONTH_W-1:0]          sm_ff;
   logic [YEAR_W-1:0]           sy_ff;
   logic signed [OFFSET_W:0]    off_ff;
   logic [YEAR_W-1:0]           y_ff;
   logic [YEAR_W-1:0]           r_ff;
   logic [STEP_W-1:0]           step_ff;
   logic [MONTH_W-1:0]          k_ff;
   logic signed [WORK_W-1:0]    acc_ff;
   logic signed [WORK_W-1:0]    p_ff;
   logic [DOY_W-1:0]            doy_ff;
   status_type                  st_ff;
   logic                        out_valid_ff;
   logic [DAY_W-1:0]            out_day_ff;
   logic [MONTH_W-1:0]          out_month_ff;
   logic [YEAR_W-1:0]           out_year_ff;
   logic [DOY_W-1:0]            out_doy_ff;
   status_type                  out_status_ff;

   logic signed [OFFSET_W:0]    off_ext;
   logic signed [OFFSET_W:0]    off_sat_in;
   logic [RES_W-1:0]            res_cur;
   logic [RES_W-1:0]            res_prev;
   logic [YEAR_W-1:0]           y_prev;
   logic                        leap_cur;
   logic                        leap_prev;
   logic [MONTH_W-1:0]          mlen_month;
   logic [MLEN_W-1:0]           mlen;
   logic signed [WORK_W-1:0]    alu_a;
   logic signed [WORK_W-1:0]    alu_b;
   logic                        alu_sub;
   logic signed [WORK_W-1:0]    alu_sum;
   logic                        alu_neg;
   logic                        p_neg;
   logic                        start_ok;
   logic                        out_free;
   logic                        req_beat;
   logic                        out_ok;
   logic                        out_bad;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_beat     = req_ch.valid && req_ch.ready;
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign p_neg        = p_ff[WORK_W-1];

   // offset saturation at the request beat
   always_comb begin
      off_ext = {req_ch.day_offset[OFFSET_W-1], req_ch.day_offset};
      if (off_ext > OFF_LIM) begin
         off_sat_in = OFF_LIM;
      end else if (off_ext < -OFF_LIM) begin
         off_sat_in = -OFF_LIM;
      end else begin
         off_sat_in = off_ext;
      end
   end

   // leap flags from the year's low bits and its residue modulo 400
   always_comb begin
      res_cur   = r_ff[RES_W-1:0];
      res_prev  = (res_cur == '0) ? RES_LAST : res_cur - RES_W'(1);
      y_prev    = y_ff - YEAR_W'(1);
      leap_cur  = (y_ff[1:0] == 2'b00) &&
                  !((res_cur == RES_W'(CENTURY)) || (res_cur == RES_W'(2 * CENTURY)) ||
                    (res_cur == RES_W'(3 * CENTURY)));
      leap_prev = (y_prev[1:0] == 2'b00) &&
                  !((res_prev == RES_W'(CENTURY)) || (res_prev == RES_W'(2 * CENTURY)) ||
                    (res_prev == RES_W'(3 * CENTURY)));
   end

   assign mlen_month = (state_ff == S_CHECK) ? sm_ff : k_ff;

   cdad_mlen u_mlen (
      .month (mlen_month),
      .leap  (leap_cur),
      .len   (mlen)
   );

   // operand selection for the shared adder
   always_comb begin
      alu_a   = p_ff;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         S_MOD: begin
            alu_a   = WORK_W'(r_ff);
            alu_b   = WORK_W'(LEAP_CYCLE) << step_ff;
            alu_sub = 1'b1;
         end
         S_ORD: begin
            alu_a = acc_ff;
            alu_b = WORK_W'(mlen);
         end
         S_OFFS: begin
            alu_a = acc_ff;
            alu_b = WORK_W'(off_ff);
         end
         S_YEAR: begin
            if (p_neg) begin
               alu_b = WORK_W'(COMMON_DAYS) + WORK_W'(leap_prev);
            end else begin
               alu_b   = WORK_W'(COMMON_DAYS) + WORK_W'(leap_cur);
               alu_sub = 1'b1;
            end
         end
         S_MONTH: begin
            alu_b   = WORK_W'(mlen);
            alu_sub = 1'b1;
         end
         default: begin
            alu_a = p_ff;
         end
      endcase
   end

   cdad_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .sub  (alu_sub),
      .sum  (alu_sum),
      .neg  (alu_neg)
   );

   assign start_ok = (sd_ff != '0) && (sm_ff != '0) && (sm_ff <= MONTH_W'(MONTHS)) &&
                     (sd_ff <= mlen) && (sy_ff <= YEAR_LAST);

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_ch.ready && (state_ff != S_DONE)) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_beat) begin
                  sd_ff    <= req_ch.start_day;
                  sm_ff    <= req_ch.start_month;
                  sy_ff    <= req_ch.start_year;
                  off_ff   <= off_sat_in;
                  y_ff     <= req_ch.start_year;
                  r_ff     <= req_ch.start_year;
                  step_ff  <= STEP_W'(MOD_TOP);
                  state_ff <= S_MOD;
               end
            end
            // restoring reduction of the year modulo 400
            S_MOD: begin
               if (!alu_neg) begin
                  r_ff <= alu_sum[YEAR_W-1:0];
               end
               if (step_ff == '0) begin
                  state_ff <= S_CHECK;
               end else begin
                  step_ff <= step_ff - STEP_W'(1);
               end
            end
            S_CHECK: begin
               if (start_ok) begin
                  k_ff     <= MONTH_W'(1);
                  acc_ff   <= WORK_W'(sd_ff) - WORK_W'(1);
                  state_ff <= S_ORD;
               end else begin
                  st_ff    <= STATUS_BAD_DATE;
                  doy_ff   <= '0;
                  state_ff <= S_DONE;
               end
            end
            // zero-based ordinal of the start date
            S_ORD: begin
               if (k_ff < sm_ff) begin
                  acc_ff <= alu_sum;
                  k_ff   <= k_ff + MONTH_W'(1);
               end else begin
                  state_ff <= S_OFFS;
               end
            end
            S_OFFS: begin
               p_ff     <= alu_sum;
               state_ff <= S_YEAR;
            end
            // one year per cycle until the day count falls inside y_ff
            S_YEAR: begin
               if (p_neg) begin
                  if (y_ff == '0) begin
                     st_ff    <= STATUS_RANGE;
                     doy_ff   <= acc_ff[DOY_W-1:0] + DOY_W'(1);
                     state_ff <= S_DONE;
                  end else begin
                     p_ff <= alu_sum;
                     y_ff <= y_prev;
                     r_ff <= YEAR_W'(res_prev);
                  end
               end else if (alu_neg) begin
                  doy_ff   <= p_ff[DOY_W-1:0] + DOY_W'(1);
                  k_ff     <= MONTH_W'(1);
                  state_ff <= S_MONTH;
               end else if (y_ff == YEAR_LAST) begin
                  st_ff    <= STATUS_RANGE;
                  doy_ff   <= acc_ff[DOY_W-1:0] + DOY_W'(1);
                  state_ff <= S_DONE;
               end else begin
                  p_ff <= alu_sum;
                  y_ff <= y_ff + YEAR_W'(1);
                  r_ff <= (res_cur == RES_LAST) ? '0 : YEAR_W'(res_cur) + YEAR_W'(1);
               end
            end
            // one month per cycle
            S_MONTH: begin
               if ((k_ff < MONTH_W'(MONTHS)) && !alu_neg) begin
                  p_ff <= alu_sum;
                  k_ff <= k_ff + MONTH_W'(1);
               end else begin
                  st_ff    <= STATUS_OK;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  out_valid_ff  <= 1'b1;
                  out_status_ff <= st_ff;
                  out_doy_ff    <= doy_ff;
                  if (st_ff == STATUS_OK) begin
                     out_day_ff   <= p_ff[DAY_W-1:0] + DAY_W'(1);
                     out_month_ff <= k_ff;
                     out_year_ff  <= y_ff;
                  end else begin
                     out_day_ff   <= sd_ff;
                     out_month_ff <= sm_ff;
                     out_year_ff  <= sy_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.res_day     = out_day_ff;
   assign rsp_ch.res_month   = out_month_ff;
   assign rsp_ch.res_year    = out_year_ff;
   assign rsp_ch.day_of_year = out_doy_ff;
   assign rsp_ch.status      = out_status_ff;

   // checks
   assign out_ok  = out_valid_ff && (out_status_ff == STATUS_OK);
   assign out_bad = out_valid_ff && (out_status_ff == STATUS_BAD_DATE);

   `CDAD_ASSERT_NEXT(a_busy_after_beat, req_beat, !req_ch.ready)
   `CDAD_ASSERT_SAME(a_year_in_range, state_ff == S_YEAR, y_ff <= YEAR_LAST)
   `CDAD_ASSERT_SAME(a_ok_has_ordinal, out_ok, (out_doy_ff != '0) && (out_day_ff != '0))
   `CDAD_ASSERT_SAME(a_bad_no_ordinal, out_bad, out_doy_ff == '0)

endmodule
